### hw/rtl/gsne_pkg.sv
// Shared types and constants for the Gaussian smoothing and noise estimate block.
// Used by gsne_ctrl, gsne_dp and the top level; depends on nothing.
package gsne_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 16;
    localparam int FRAC_BITS   = 8;
    localparam int OUT_W       = 24;
    localparam int SUM_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int DIV_STEPS   = 64;
    localparam int SQRT_STEPS  = 32;
    localparam int ITER_W      = 6;

    localparam logic [OUT_W-1:0] MAX_OUT = '1;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAR    = 2'd2;

    localparam logic [WEIGHT_W-1:0] RST_CENTER = 16'd26386;
    localparam logic [WEIGHT_W-1:0] RST_NEAR   = 16'd16004;
    localparam logic [WEIGHT_W-1:0] RST_FAR    = 16'd3571;

    typedef struct packed {
        logic take;
        logic mul;
        logic fir_sum;
        logic square;
        logic accum;
        logic emit_mid;
        logic emit_flush;
        logic emit_last;
        logic shift;
        logic clear;
        logic div_start;
        logic div_step;
        logic sqrt_step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic n_ge1;
        logic n_ge2;
        logic rec_end;
    } t_stat;

endpackage

### hw/rtl/gsne_dp.sv
// Datapath: weight registers, sample window, FIR, residual accumulator,
// serial divider, serial square root and the output register. Uses gsne_pkg.
module gsne_dp import gsne_pkg::*; #(
    parameter int MAX_SAMPLES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WEIGHT_W-1:0]  i_cfg_data,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_last,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [OUT_W-1:0]     o_smoothed,
    output logic                 o_record_end,
    output logic [OUT_W-1:0]     o_noise
);

    localparam int CW = $clog2(MAX_SAMPLES);
    localparam int TW = $clog2(MAX_SAMPLES + 1);

    logic [WEIGHT_W-1:0] r_center, r_near, r_far;
    logic [SAMPLE_W-1:0] r_win [4];
    logic [CW-1:0]       r_cnt;
    logic [SAMPLE_W-1:0] r_cur;
    logic                r_end;
    logic [32:0]         r_p_far, r_p_near;
    logic [31:0]         r_p_ctr;
    logic [OUT_W-1:0]    r_sm;
    logic [47:0]         r_sq;
    logic [SUM_W-1:0]    r_ssum;
    logic [SUM_W-1:0]    r_q;
    logic [TW-1:0]       r_rem;
    logic [33:0]         r_srem;
    logic [31:0]         r_root;
    logic                r_o_valid;
    logic [OUT_W-1:0]    r_o_sm, r_o_noise;
    logic                r_o_end;

    logic                n_ge4;
    logic [16:0]         n_pair_far, n_pair_near;
    logic [34:0]         n_acc;
    logic [26:0]         n_fir;
    logic [OUT_W-1:0]    n_fir_sat;
    logic [OUT_W-1:0]    n_raw8, n_diff;
    logic [TW-1:0]       n_total;
    logic [TW:0]         n_drem;
    logic [35:0]         n_srem, n_trial;
    logic [OUT_W-1:0]    n_noise;

    assign n_ge4       = r_cnt >= CW'(4);
    assign n_pair_far  = 17'(r_win[3]) + 17'(r_cur);
    assign n_pair_near = 17'(r_win[2]) + 17'(r_win[0]);
    assign n_acc       = 35'(r_p_far) + 35'(r_p_near) + 35'(r_p_ctr);
    assign n_fir       = n_acc[34:FRAC_BITS];
    assign n_fir_sat   = (|n_fir[26:OUT_W]) ? MAX_OUT : n_fir[OUT_W-1:0];
    assign n_raw8      = {r_win[1], 8'h00};
    assign n_diff      = (n_raw8 > r_sm) ? (n_raw8 - r_sm) : (r_sm - n_raw8);
    assign n_total     = TW'(r_cnt) + TW'(1);
    assign n_drem      = {r_rem, r_q[SUM_W-1]};
    assign n_srem      = {r_srem, r_q[SUM_W-1:SUM_W-2]};
    assign n_trial     = {2'b00, r_root, 2'b01};
    assign n_noise     = (|r_root[31:OUT_W]) ? MAX_OUT : r_root[OUT_W-1:0];

    assign o_stat.out_free = !r_o_valid || i_out_ready;
    assign o_stat.n_ge1    = r_cnt != '0;
    assign o_stat.n_ge2    = r_cnt >= CW'(2);
    assign o_stat.rec_end  = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= RST_CENTER;
            r_near   <= RST_NEAR;
            r_far    <= RST_FAR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CENTER: r_center <= i_cfg_data;
                REG_NEAR:   r_near   <= i_cfg_data;
                REG_FAR:    r_far    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '{default: '0};
            r_cnt  <= '0;
            r_ssum <= '0;
        end else if (i_cmd.clear) begin
            r_win  <= '{default: '0};
            r_cnt  <= '0;
            r_ssum <= '0;
        end else begin
            if (i_cmd.shift) begin
                r_win[3] <= r_win[2];
                r_win[2] <= r_win[1];
                r_win[1] <= r_win[0];
                r_win[0] <= r_cur;
                r_cnt    <= r_cnt + CW'(1);
            end
            if (i_cmd.accum) begin
                r_ssum <= r_ssum + SUM_W'(r_sq);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_cur <= i_sample;
            r_end <= i_last || (r_cnt == CW'(MAX_SAMPLES - 1));
        end
        if (i_cmd.mul) begin
            r_p_far  <= 33'(r_far) * 33'(n_pair_far);
            r_p_near <= 33'(r_near) * 33'(n_pair_near);
            r_p_ctr  <= 32'(r_center) * 32'(r_win[1]);
        end
        if (i_cmd.fir_sum) begin
            r_sm <= n_ge4 ? n_fir_sat : n_raw8;
        end
        if (i_cmd.square) begin
            r_sq <= n_ge4 ? 48'(n_diff) * 48'(n_diff) : '0;
        end
        if (i_cmd.div_start) begin
            r_q    <= r_ssum;
            r_rem  <= '0;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.div_step) begin
            if (n_drem >= (TW+1)'(n_total)) begin
                r_rem <= TW'(n_drem - (TW+1)'(n_total));
                r_q   <= {r_q[SUM_W-2:0], 1'b1};
            end else begin
                r_rem <= n_drem[TW-1:0];
                r_q   <= {r_q[SUM_W-2:0], 1'b0};
            end
        end else if (i_cmd.sqrt_step) begin
            r_q <= {r_q[SUM_W-3:0], 2'b00};
            if (n_srem >= n_trial) begin
                r_srem <= 34'(n_srem - n_trial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_srem <= n_srem[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit_mid || i_cmd.emit_flush || i_cmd.emit_last) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_mid) begin
            r_o_sm    <= r_sm;
            r_o_end   <= 1'b0;
            r_o_noise <= '0;
        end else if (i_cmd.emit_flush) begin
            r_o_sm    <= {r_win[0], 8'h00};
            r_o_end   <= 1'b0;
            r_o_noise <= '0;
        end else if (i_cmd.emit_last) begin
            r_o_sm    <= {r_cur, 8'h00};
            r_o_end   <= 1'b1;
            r_o_noise <= n_noise;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_smoothed   = r_o_sm;
    assign o_record_end = r_o_end;
    assign o_noise      = r_o_noise;

`ifndef SYNTHESIS
    a_noise_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_end) |-> (r_o_noise == '0))
        else $error("noise nonzero on a result that does not end a record");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_cnt == '0 && r_ssum == '0))
        else $error("record state not cleared");
    a_hold_unaccepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_out_ready) |-> o_stat.out_free == 1'b0)
        else $error("output register reported free while a beat waits");
`endif

endmodule

### hw/rtl/gsne_ctrl.sv
// Controller: one-hot sequencer that steps the datapath through filter,
// residual, emit, divide and root phases. Uses gsne_pkg.
module gsne_ctrl import gsne_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL   = 10'b0000000010,
        S_SUM   = 10'b0000000100,
        S_SQR   = 10'b0000001000,
        S_ACC   = 10'b0000010000,
        S_EMITA = 10'b0000100000,
        S_EMITB = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_SQRT  = 10'b0100000000,
        S_EMITC = 10'b1000000000
    } t_state;

    t_state            r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.fir_sum = 1'b1;
                n_state       = S_SQR;
            end
            S_SQR: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = S_EMITA;
            end
            S_EMITA: begin
                if (!i_stat.n_ge2 || i_stat.out_free) begin
                    o_cmd.emit_mid = i_stat.n_ge2;
                    if (i_stat.rec_end) begin
                        n_state = S_EMITB;
                    end else begin
                        o_cmd.shift = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_EMITB: begin
                if (!i_stat.n_ge1 || i_stat.out_free) begin
                    o_cmd.emit_flush = i_stat.n_ge1;
                    o_cmd.div_start  = 1'b1;
                    n_iter           = ITER_W'(DIV_STEPS - 1);
                    n_state          = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_iter         = r_iter - ITER_W'(1);
                if (r_iter == '0) begin
                    n_iter  = ITER_W'(SQRT_STEPS - 1);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_iter          = r_iter - ITER_W'(1);
                if (r_iter == '0) begin
                    n_state = S_EMITC;
                end
            end
            S_EMITC: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_last = 1'b1;
                    o_cmd.clear     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef SYNTHESIS
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.emit_mid, o_cmd.emit_flush, o_cmd.emit_last}))
        else $error("more than one beat loaded in a cycle");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_mid || o_cmd.emit_flush || o_cmd.emit_last) |-> i_stat.out_free)
        else $error("beat loaded over a waiting result");
    a_clear_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> (o_cmd.emit_last && !o_cmd.shift))
        else $error("record cleared without its final beat");
`endif

endmodule

### hw/rtl/gaussian_smooth_noise_estimate.sv
// Top level of the five-tap Gaussian smoother with RMS residual noise figure.
// Instantiates gsne_ctrl and gsne_dp; uses gsne_pkg.
//
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_ready   i_sample, i_last
//  output   out        o_out_valid / i_out_ready o_smoothed, o_record_end, o_noise
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A sample that does not end its record steps through accept, multiply, sum,
// square, accumulate and emit. The last sample adds one flush beat, a restoring
// division, a square root and the final beat.
// Reset is synchronous and restores the default weights and an empty record.
// A beat waiting in the output register holds the emit states until taken.
module gaussian_smooth_noise_estimate import gsne_pkg::*; #(
    parameter int MAX_SAMPLES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_last,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [OUT_W-1:0]     o_smoothed,
    output logic                 o_record_end,
    output logic [OUT_W-1:0]     o_noise,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WEIGHT_W-1:0]  i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    gsne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    gsne_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (i_sample),
        .i_last       (i_last),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_smoothed   (o_smoothed),
        .o_record_end (o_record_end),
        .o_noise      (o_noise)
    );

endmodule
